[hw/rtl/srde_pkg.sv]
// Shared constants for the SIMON round difference enumerator pipeline.
package srde_pkg;

  // Default word size of the cipher half
  localparam int WORD_BITS_DEF = 32;

  // Fixed port widths
  localparam int IDX_BITS    = 32;
  localparam int IDX_SEL     = 5;
  localparam int OUT_BITS    = 32;
  localparam int WEIGHT_BITS = 6;
  localparam int WEIGHT_MAX  = 63;

  // Rank is built from 8-bit groups
  localparam int GRP_BITS = 8;
  localparam int LOC_W    = 3;
  localparam int TOT_W    = 4;

  // Round function taps and tie distance
  localparam int TAP_PREV = 1;
  localparam int TAP_FAR  = 8;
  localparam int TAP_ROT  = 2;
  localparam int TAP_FWD  = 6;
  localparam int TIE_DIST = 7;

endpackage

[hw/rtl/simon_round_diff_enumerator_core.sv]
// SIMON round differential transition enumerator, top level.
// Pipeline: four register stages (mark, group count, rank sum, fill/output register)
// lie between the input accept and result valid.
// Throughput: one item per cycle while out_ready is high; each stage holds its item only while the
// next stage is full and stalled, so the output register sets the pace.
// Reset: synchronous, active high; clears all stage valid bits, data is not reset.
module simon_round_diff_enumerator_core #(
  parameter int WORD_BITS = srde_pkg::WORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [srde_pkg::IDX_BITS-1:0]    left_diff,
  input  logic [srde_pkg::IDX_BITS-1:0]    right_diff,
  input  logic [srde_pkg::IDX_BITS-1:0]    choice_index,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [srde_pkg::OUT_BITS-1:0]    next_left,
  output logic [srde_pkg::OUT_BITS-1:0]    next_right,
  output logic [srde_pkg::WEIGHT_BITS-1:0] weight,
  output logic                             index_ok
);
  import srde_pkg::*;

  localparam int NGRP  = (WORD_BITS + GRP_BITS - 1) / GRP_BITS;
  localparam int CNT_W = $clog2(WORD_BITS + 1);

  // Stage 1 outputs
  logic                 s1_valid, s1_ready;
  logic [WORD_BITS-1:0] s1_l, s1_r, s1_free, s1_tie, s1_base;
  logic [IDX_BITS-1:0]  s1_idx;

  // Stage 2 outputs
  logic                            s2_valid, s2_ready;
  logic [WORD_BITS-1:0]            s2_l, s2_r, s2_free, s2_tie, s2_base;
  logic [IDX_BITS-1:0]             s2_idx;
  logic [NGRP*GRP_BITS-1:0][LOC_W-1:0] s2_loc;
  logic [NGRP-1:0][TOT_W-1:0]      s2_tot;

  // Stage 3 outputs
  logic                            s3_valid, s3_ready;
  logic [WORD_BITS-1:0]            s3_l, s3_r, s3_free, s3_tie, s3_base;
  logic [IDX_BITS-1:0]             s3_idx;
  logic [WORD_BITS-1:0][CNT_W-1:0] s3_rank;
  logic [CNT_W-1:0]                s3_cnt;

  srde_mark #(.WORD_BITS(WORD_BITS)) u_mark (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .left_diff    (left_diff),
    .right_diff   (right_diff),
    .choice_index (choice_index),
    .out_valid    (s1_valid),
    .out_ready    (s1_ready),
    .l_word       (s1_l),
    .r_word       (s1_r),
    .idx          (s1_idx),
    .free_map     (s1_free),
    .tie_map      (s1_tie),
    .base         (s1_base)
  );

  srde_rank_local #(.WORD_BITS(WORD_BITS), .NGRP(NGRP)) u_rank_local (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .l_in      (s1_l),
    .r_in      (s1_r),
    .idx_in    (s1_idx),
    .free_in   (s1_free),
    .tie_in    (s1_tie),
    .base_in   (s1_base),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .l_word    (s2_l),
    .r_word    (s2_r),
    .idx       (s2_idx),
    .free_map  (s2_free),
    .tie_map   (s2_tie),
    .base      (s2_base),
    .loc       (s2_loc),
    .tot       (s2_tot)
  );

  srde_rank_sum #(.WORD_BITS(WORD_BITS), .NGRP(NGRP), .CNT_W(CNT_W)) u_rank_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .l_in      (s2_l),
    .r_in      (s2_r),
    .idx_in    (s2_idx),
    .free_in   (s2_free),
    .tie_in    (s2_tie),
    .base_in   (s2_base),
    .loc_in    (s2_loc),
    .tot_in    (s2_tot),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .l_word    (s3_l),
    .r_word    (s3_r),
    .idx       (s3_idx),
    .free_map  (s3_free),
    .tie_map   (s3_tie),
    .base      (s3_base),
    .rank      (s3_rank),
    .cnt       (s3_cnt)
  );

  srde_fill #(.WORD_BITS(WORD_BITS), .CNT_W(CNT_W)) u_fill (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s3_valid),
    .in_ready   (s3_ready),
    .l_in       (s3_l),
    .r_in       (s3_r),
    .idx_in     (s3_idx),
    .free_in    (s3_free),
    .tie_in     (s3_tie),
    .base_in    (s3_base),
    .rank_in    (s3_rank),
    .cnt_in     (s3_cnt),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .next_left  (next_left),
    .next_right (next_right),
    .weight     (weight),
    .index_ok   (index_ok)
  );

  // Weight never exceeds the word size
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(weight) <= WORD_BITS))
    else $error("weight above word size");

  // A weight covering the whole index always accepts it
  a_wide_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (32'(weight) >= IDX_BITS)) |-> index_ok)
    else $error("index rejected at full weight");

  // Free positions and ties never overlap in the rank stage
  a_free_tie: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> ((s3_free & s3_tie) == '0))
    else $error("tied position counted as free");

  // Stage count equals the last rank plus its own free bit
  a_cnt_total: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> (s3_cnt == s3_rank[WORD_BITS-1] + CNT_W'(s3_free[WORD_BITS-1])))
    else $error("rank total mismatch");

endmodule

[hw/rtl/srde_mark.sv]
// Stage 1: marks free and tied AND-term positions and forms the base difference.
module srde_mark #(
  parameter int WORD_BITS = srde_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [srde_pkg::IDX_BITS-1:0] left_diff,
  input  logic [srde_pkg::IDX_BITS-1:0] right_diff,
  input  logic [srde_pkg::IDX_BITS-1:0] choice_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [WORD_BITS-1:0]          l_word,
  output logic [WORD_BITS-1:0]          r_word,
  output logic [srde_pkg::IDX_BITS-1:0] idx,
  output logic [WORD_BITS-1:0]          free_map,
  output logic [WORD_BITS-1:0]          tie_map,
  output logic [WORD_BITS-1:0]          base
);
  import srde_pkg::*;

  logic                 vld;
  logic [WORD_BITS-1:0] a_in;
  logic [WORD_BITS-1:0] mark_c;
  logic [WORD_BITS-1:0] tie_c;
  logic [WORD_BITS-1:0] base_c;

  assign a_in = WORD_BITS'(left_diff);

  // Per-position marks, ties and rotated base
  for (genvar i = 0; i < WORD_BITS; i++) begin : g_bit
    localparam int P1 = (i + WORD_BITS - TAP_PREV) % WORD_BITS;
    localparam int P8 = (i + WORD_BITS - TAP_FAR) % WORD_BITS;
    localparam int P2 = (i + WORD_BITS - TAP_ROT) % WORD_BITS;
    localparam int P6 = (i + TAP_FWD) % WORD_BITS;
    localparam int T7 = (i + TIE_DIST) % WORD_BITS;
    assign mark_c[i] = a_in[P1] | a_in[P8];
    // position i+7 follows position i
    assign tie_c[T7] = ~a_in[P1] & a_in[P6] & a_in[P8];
    assign base_c[i] = (a_in[P1] & a_in[P8]) ^ a_in[P2];
  end

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      l_word   <= a_in;
      r_word   <= WORD_BITS'(right_diff);
      idx      <= choice_index;
      free_map <= mark_c & ~tie_c;
      tie_map  <= tie_c;
      base     <= base_c;
    end
  end

endmodule

[hw/rtl/srde_rank_local.sv]
// Stage 2: counts free positions inside each 8-bit group.
module srde_rank_local #(
  parameter int WORD_BITS = srde_pkg::WORD_BITS_DEF,
  parameter int NGRP      = (WORD_BITS + srde_pkg::GRP_BITS - 1) / srde_pkg::GRP_BITS
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [WORD_BITS-1:0]                        l_in,
  input  logic [WORD_BITS-1:0]                        r_in,
  input  logic [srde_pkg::IDX_BITS-1:0]               idx_in,
  input  logic [WORD_BITS-1:0]                        free_in,
  input  logic [WORD_BITS-1:0]                        tie_in,
  input  logic [WORD_BITS-1:0]                        base_in,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic [WORD_BITS-1:0]                        l_word,
  output logic [WORD_BITS-1:0]                        r_word,
  output logic [srde_pkg::IDX_BITS-1:0]               idx,
  output logic [WORD_BITS-1:0]                        free_map,
  output logic [WORD_BITS-1:0]                        tie_map,
  output logic [WORD_BITS-1:0]                        base,
  output logic [NGRP*srde_pkg::GRP_BITS-1:0][srde_pkg::LOC_W-1:0] loc,
  output logic [NGRP-1:0][srde_pkg::TOT_W-1:0]        tot
);
  import srde_pkg::*;

  localparam int PAD = NGRP * GRP_BITS;

  logic                          vld;
  logic [PAD-1:0]                freep;
  logic [PAD-1:0][LOC_W-1:0]     loc_c;
  logic [NGRP-1:0][TOT_W-1:0]    tot_c;

  assign freep = PAD'(free_in);

  // Exclusive prefix count within each group
  always_comb begin : p_local
    logic [TOT_W-1:0] acc;
    acc = '0;
    for (int g = 0; g < NGRP; g++) begin
      acc = '0;
      for (int b = 0; b < GRP_BITS; b++) begin
        loc_c[g*GRP_BITS+b] = LOC_W'(acc);
        acc = acc + TOT_W'(freep[g*GRP_BITS+b]);
      end
      tot_c[g] = acc;
    end
  end

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      l_word   <= l_in;
      r_word   <= r_in;
      idx      <= idx_in;
      free_map <= free_in;
      tie_map  <= tie_in;
      base     <= base_in;
      loc      <= loc_c;
      tot      <= tot_c;
    end
  end

endmodule

[hw/rtl/srde_rank_sum.sv]
// Stage 3: adds group offsets to local counts, giving each position's index bit.
module srde_rank_sum #(
  parameter int WORD_BITS = srde_pkg::WORD_BITS_DEF,
  parameter int NGRP      = (WORD_BITS + srde_pkg::GRP_BITS - 1) / srde_pkg::GRP_BITS,
  parameter int CNT_W     = $clog2(WORD_BITS + 1)
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [WORD_BITS-1:0]                        l_in,
  input  logic [WORD_BITS-1:0]                        r_in,
  input  logic [srde_pkg::IDX_BITS-1:0]               idx_in,
  input  logic [WORD_BITS-1:0]                        free_in,
  input  logic [WORD_BITS-1:0]                        tie_in,
  input  logic [WORD_BITS-1:0]                        base_in,
  input  logic [NGRP*srde_pkg::GRP_BITS-1:0][srde_pkg::LOC_W-1:0] loc_in,
  input  logic [NGRP-1:0][srde_pkg::TOT_W-1:0]        tot_in,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic [WORD_BITS-1:0]                        l_word,
  output logic [WORD_BITS-1:0]                        r_word,
  output logic [srde_pkg::IDX_BITS-1:0]               idx,
  output logic [WORD_BITS-1:0]                        free_map,
  output logic [WORD_BITS-1:0]                        tie_map,
  output logic [WORD_BITS-1:0]                        base,
  output logic [WORD_BITS-1:0][CNT_W-1:0]             rank,
  output logic [CNT_W-1:0]                            cnt
);
  import srde_pkg::*;

  logic                           vld;
  logic [NGRP-1:0][CNT_W-1:0]     off_c;
  logic [WORD_BITS-1:0][CNT_W-1:0] rank_c;
  logic [CNT_W-1:0]               cnt_c;

  // Running group offsets, then per-position rank
  always_comb begin : p_sum
    logic [CNT_W-1:0] acc;
    acc = '0;
    for (int g = 0; g < NGRP; g++) begin
      off_c[g] = acc;
      acc = acc + CNT_W'(tot_in[g]);
    end
    cnt_c = acc;
    for (int i = 0; i < WORD_BITS; i++) begin
      rank_c[i] = off_c[i/GRP_BITS] + CNT_W'(loc_in[i]);
    end
  end

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      l_word   <= l_in;
      r_word   <= r_in;
      idx      <= idx_in;
      free_map <= free_in;
      tie_map  <= tie_in;
      base     <= base_in;
      rank     <= rank_c;
      cnt      <= cnt_c;
    end
  end

endmodule

[hw/rtl/srde_fill.sv]
// Stage 4: drops index bits into free positions, copies tied bits, registers the result.
module srde_fill #(
  parameter int WORD_BITS = srde_pkg::WORD_BITS_DEF,
  parameter int CNT_W     = $clog2(WORD_BITS + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [WORD_BITS-1:0]             l_in,
  input  logic [WORD_BITS-1:0]             r_in,
  input  logic [srde_pkg::IDX_BITS-1:0]    idx_in,
  input  logic [WORD_BITS-1:0]             free_in,
  input  logic [WORD_BITS-1:0]             tie_in,
  input  logic [WORD_BITS-1:0]             base_in,
  input  logic [WORD_BITS-1:0][CNT_W-1:0]  rank_in,
  input  logic [CNT_W-1:0]                 cnt_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [srde_pkg::OUT_BITS-1:0]    next_left,
  output logic [srde_pkg::OUT_BITS-1:0]    next_right,
  output logic [srde_pkg::WEIGHT_BITS-1:0] weight,
  output logic                             index_ok
);
  import srde_pkg::*;

  logic                 vld;
  logic [WORD_BITS-1:0] filled;
  logic [WORD_BITS-1:0] res_c;
  logic [IDX_BITS-1:0]  hi_mask;
  logic                 ok_c;

  // Free position i takes index bit rank[i]; bits past the index width take 0
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      if (free_in[i] && (32'(rank_in[i]) < IDX_BITS)) begin
        filled[i] = base_in[i] ^ idx_in[rank_in[i][IDX_SEL-1:0]];
      end else begin
        filled[i] = base_in[i];
      end
    end
  end

  // A tied bit copies its root seven places below; roots are never tied themselves
  for (genvar i = 0; i < WORD_BITS; i++) begin : g_tie
    localparam int SRC = (i + WORD_BITS - TIE_DIST) % WORD_BITS;
    assign res_c[i] = tie_in[i] ? filled[SRC] : filled[i];
  end

  // Index in range: no set bit at or above the weight
  always_comb begin
    for (int j = 0; j < IDX_BITS; j++) begin
      hi_mask[j] = (j >= 32'(cnt_in));
    end
    ok_c = (32'(cnt_in) >= IDX_BITS) || ((idx_in & hi_mask) == '0);
  end

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      next_left  <= OUT_BITS'(r_in ^ res_c);
      next_right <= OUT_BITS'(l_in);
      weight     <= (32'(cnt_in) > WEIGHT_MAX) ? WEIGHT_BITS'(WEIGHT_MAX)
                                               : WEIGHT_BITS'(cnt_in);
      index_ok   <= ok_c;
    end
  end

endmodule

[tb/sv/simon_round_diff_enumerator_checker.sv]
// Scoreboard for the SIMON round difference enumerator: predicts and compares each result.
module simon_round_diff_enumerator_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [srde_pkg::IDX_BITS-1:0]    left_diff,
  input  logic [srde_pkg::IDX_BITS-1:0]    right_diff,
  input  logic [srde_pkg::IDX_BITS-1:0]    choice_index,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [srde_pkg::OUT_BITS-1:0]    next_left,
  input  logic [srde_pkg::OUT_BITS-1:0]    next_right,
  input  logic [srde_pkg::WEIGHT_BITS-1:0] weight,
  input  logic                             index_ok,
  output int                               fail_count,
  output int                               expect_depth,
  output int                               checked_count,
  output int                               in_range_count
);
  import srde_pkg::*;

  localparam int WB = WORD_BITS_DEF;

  typedef struct packed {
    logic [OUT_BITS-1:0]    nl;
    logic [OUT_BITS-1:0]    nr;
    logic [WEIGHT_BITS-1:0] w;
    logic                   ok;
  } diff_result_t;

  diff_result_t transitions_due[$];
  int           mismatches;
  int           checked;
  int           in_range;

  function automatic logic [WB-1:0] rotl(logic [WB-1:0] x, int k);
    return (x << k) | (x >> (WB - k));
  endfunction

  // Expected next difference pair, weight and range flag for one item
  function automatic diff_result_t enumerate_transition(logic [IDX_BITS-1:0] l,
                                                        logic [IDX_BITS-1:0] r,
                                                        logic [IDX_BITS-1:0] c);
    logic [WB-1:0] a;
    logic [WB-1:0] marked;
    logic [WB-1:0] tied;
    logic [WB-1:0] word;
    int            root [WB];
    int            free_cnt;
    int            t;
    logic          s1, s8, s6;
    diff_result_t  res;

    a = '0;
    for (int i = 0; i < WB && i < IDX_BITS; i++) a[i] = l[i];
    marked = '0;
    tied = '0;
    for (int i = 0; i < WB; i++) root[i] = i;

    // mark varying AND positions, record ties; a later root overwrites
    for (int i = 0; i < WB; i++) begin
      s1 = a[(i + WB - TAP_PREV) % WB];
      s8 = a[(i + WB - TAP_FAR) % WB];
      s6 = a[(i + TAP_FWD) % WB];
      if (s1 | s8) begin
        marked[i] = 1'b1;
        if (!s1 && s6 && s8) begin
          t = (i + TIE_DIST) % WB;
          tied[t] = 1'b1;
          root[t] = i;
        end
      end
    end

    word = (rotl(a, TAP_PREV) & rotl(a, TAP_FAR)) ^ rotl(a, TAP_ROT);

    // free bits take index bits from the bottom up
    free_cnt = 0;
    for (int i = 0; i < WB; i++) begin
      if (marked[i] && !tied[i]) begin
        if (free_cnt < IDX_BITS) word[i] = word[i] ^ c[free_cnt];
        free_cnt++;
      end
    end

    // tied bits copy their root, in position order
    for (int i = 0; i < WB; i++) begin
      if (tied[i]) word[i] = word[root[i]];
    end

    res.nl = r ^ OUT_BITS'(word);
    res.nr = OUT_BITS'(a);
    res.w  = (free_cnt > WEIGHT_MAX) ? WEIGHT_BITS'(WEIGHT_MAX) : WEIGHT_BITS'(free_cnt);
    res.ok = (free_cnt >= IDX_BITS) ? 1'b1 : (64'(c) < (64'd1 << free_cnt));
    return res;
  endfunction

  // Compare outgoing items first, then queue the prediction of an incoming one
  always @(posedge clk) begin
    diff_result_t want;
    diff_result_t got;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{nl: next_left, nr: next_right, w: weight, ok: index_ok};
        if (transitions_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result item: next_left=%h next_right=%h weight=%0d ok=%0b",
                     got.nl, got.nr, got.w, got.ok);
        end else begin
          want = transitions_due.pop_front();
          checked++;
          if (want.ok) in_range++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp nl=%h nr=%h w=%0d ok=%0b, got nl=%h nr=%h w=%0d ok=%0b",
                       want.nl, want.nr, want.w, want.ok, got.nl, got.nr, got.w, got.ok);
          end
        end
      end
      if (in_valid && in_ready)
        transitions_due.push_back(enumerate_transition(left_diff, right_diff, choice_index));
    end
    fail_count <= mismatches;
    expect_depth <= transitions_due.size();
    checked_count <= checked;
    in_range_count <= in_range;
  end

endmodule

[tb/sv/simon_round_diff_enumerator_core_tb.sv]
// Top of the SIMON round difference enumerator testbench: clock, reset, stimulus, verdict.
module simon_round_diff_enumerator_core_tb;
  import srde_pkg::*;

  localparam int RAND_ITEMS  = 1230;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_GAP     = 17;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic [IDX_BITS-1:0]    left_diff;
  logic [IDX_BITS-1:0]    right_diff;
  logic [IDX_BITS-1:0]    choice_index;
  logic                   out_valid;
  logic                   out_ready;
  logic [OUT_BITS-1:0]    next_left;
  logic [OUT_BITS-1:0]    next_right;
  logic [WEIGHT_BITS-1:0] weight;
  logic                   index_ok;

  int fail_count;
  int expect_depth;
  int checked_count;
  int in_range_count;
  int sent_count;
  int idle_cycles;
  bit calm;

  simon_round_diff_enumerator_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .left_diff    (left_diff),
    .right_diff   (right_diff),
    .choice_index (choice_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .next_left    (next_left),
    .next_right   (next_right),
    .weight       (weight),
    .index_ok     (index_ok)
  );

  simon_round_diff_enumerator_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .left_diff      (left_diff),
    .right_diff     (right_diff),
    .choice_index   (choice_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .next_left      (next_left),
    .next_right     (next_right),
    .weight         (weight),
    .index_ok       (index_ok),
    .fail_count     (fail_count),
    .expect_depth   (expect_depth),
    .checked_count  (checked_count),
    .in_range_count (in_range_count)
  );

  // Clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Present one item after a random gap and hold it until accepted
  task automatic send_diff(input logic [IDX_BITS-1:0] l, input logic [IDX_BITS-1:0] r,
                           input logic [IDX_BITS-1:0] c);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    left_diff    <= l;
    right_diff   <= r;
    choice_index <= c;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  // Result side: random stall before each item
  initial begin
    int gap;
    out_ready <= 1'b0;
    repeat (2) @(posedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    logic [IDX_BITS-1:0] l;
    logic [IDX_BITS-1:0] c;
    int                  pos;
    sent_count = 0;
    calm = 1'b0;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    left_diff    <= '0;
    right_diff   <= '0;
    choice_index <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // zero and all-ones words, nothing free vs everything free
    send_diff(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_diff(32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff);
    send_diff(32'hffff_ffff, 32'h0000_0000, 32'h0000_0000);
    send_diff(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    // one bit set: two free bits, index at and past the range edge
    send_diff(32'h0000_0001, 32'h0000_0000, 32'h0000_0003);
    send_diff(32'h0000_0001, 32'h0000_0000, 32'h0000_0004);
    send_diff(32'h8000_0000, 32'h1234_5678, 32'h0000_0002);
    send_diff(32'h8000_0000, 32'h0000_0000, 32'hffff_ffff);
    // tied position in the middle of the word
    send_diff(32'h0000_4001, 32'h0000_0000, 32'h0000_0000);
    send_diff(32'h0000_4001, 32'h0000_0000, 32'hffff_ffff);
    // tie that wraps past the top of the word
    send_diff(32'h0010_0004, 32'ha5a5_a5a5, 32'h0000_01ff);
    send_diff(32'h0010_0004, 32'h0000_0000, 32'h0000_0000);
    // dense and periodic patterns
    send_diff(32'haaaa_aaaa, 32'h0000_0000, 32'hffff_ffff);
    send_diff(32'h5555_5555, 32'hffff_ffff, 32'h0000_0000);
    send_diff(32'h0080_8080, 32'h0f0f_0f0f, 32'h0000_002a);
    send_diff(32'h0101_0101, 32'hf0f0_f0f0, 32'h0000_ffff);
    send_diff(32'hc000_3000, 32'h0000_0001, 32'h0000_0007);
    send_diff(32'hffff_fffe, 32'h8000_0000, 32'h7fff_ffff);
    send_diff(32'h7fff_ffff, 32'h0000_0000, 32'h8000_0000);
    send_diff(32'h0000_ffff, 32'hdead_beef, 32'h0000_ffff);

    // random part: sparse words, tie-heavy words and full random words
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: l = $urandom & $urandom & $urandom;
        1: l = (32'd1 << $urandom_range(0, 31)) | (32'd1 << $urandom_range(0, 31));
        2: begin
          // bit p-8 and p+6 set, p-1 clear, plus a little noise
          pos = $urandom_range(0, 31);
          l = ($urandom & $urandom & $urandom & $urandom);
          l[(pos + 24) % 32] = 1'b1;
          l[(pos + 6) % 32]  = 1'b1;
          l[(pos + 31) % 32] = 1'b0;
        end
        default: l = $urandom;
      endcase
      c = $urandom_range(0, 1) ? $urandom : ($urandom >> $urandom_range(0, 31));
      send_diff(l, $urandom, c);
    end

    calm = 1'b0;
    in_valid <= 1'b0;
    do @(posedge clk); while (expect_depth != 0);
    repeat (12) @(posedge clk);

    $display("covered %0d items incl. tie, wrap and range-edge cases; %0d results compared",
             sent_count, checked_count);
    $display("results with index in range: %0d, out of range: %0d",
             in_range_count, checked_count - in_range_count);
    if (fail_count == 0 && expect_depth == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[simon_round_diff_enumerator_core.f]
hw/rtl/srde_pkg.sv
hw/rtl/srde_mark.sv
hw/rtl/srde_rank_local.sv
hw/rtl/srde_rank_sum.sv
hw/rtl/srde_fill.sv
hw/rtl/simon_round_diff_enumerator_core.sv
tb/sv/simon_round_diff_enumerator_checker.sv
tb/sv/simon_round_diff_enumerator_core_tb.sv
